### src/flat_json_object_parser_unit_assert.svh
// Assertion macros used by the port checker file.
// Depends on nothing; included by bare file name.
`ifndef FLAT_JSON_OBJECT_PARSER_UNIT_ASSERT_SVH
`define FLAT_JSON_OBJECT_PARSER_UNIT_ASSERT_SVH
// Assert that a implies b at every edge outside reset.
`define FJP_ASSERT_IMP(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// Assert that a at one edge implies b at the next edge.
`define FJP_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`endif

### src/fjp_pkg.sv
// Shared types and constants of the flat JSON object parser.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
package fjp_pkg;
  localparam int PendingDepth = 16;
  localparam int PendIdxW = $clog2(PendingDepth);
  localparam int PendCntW = $clog2(PendingDepth + 1);
  localparam int QueueDepth = 4;
  localparam int QIdxW = $clog2(QueueDepth);

  typedef enum logic [3:0] {
    PH_START, PH_OPEN, PH_COMMA, PH_KEYWAIT, PH_KEYSTR, PH_COLON,
    PH_VALWAIT, PH_VALSTR, PH_BARE, PH_AFTERVAL, PH_DONE, PH_FAILED
  } phase_t;

  typedef enum logic [2:0] {
    K_KEYCH = 3'd0, K_VALCH = 3'd1, K_KEYEND = 3'd2, K_PAIREND = 3'd3,
    K_DONE = 3'd4, K_ERROR = 3'd5
  } kind_t;

  localparam logic [2:0] E_NOBRACE = 3'd0;
  localparam logic [2:0] E_BADKEY = 3'd1;
  localparam logic [2:0] E_NOCOLON = 3'd2;
  localparam logic [2:0] E_BADVAL = 3'd3;
  localparam logic [2:0] E_NOSEP = 3'd4;
  localparam logic [2:0] E_OVERFLOW = 3'd5;

  // Item class decided by the front part.
  typedef enum logic [1:0] {
    C_BYTE, C_WS, C_END
  } cls_t;

  typedef struct packed {
    logic [7:0] text_byte;
    cls_t cls;
  } tok_t;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic [4:0] hex_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") hex_of = 5'(c - 8'h30);
    else if (c >= "a" && c <= "f") hex_of = 5'(c - 8'h57);
    else if (c >= "A" && c <= "F") hex_of = 5'(c - 8'h37);
    else hex_of = 5'd16;
  endfunction

  // Read four characters the way strtoul base 16 does; fold large codes to '?'.
  function automatic logic [7:0] decode_u(input logic [31:0] w);
    logic [7:0] c [4];
    logic [2:0] pos;
    logic [16:0] mag;
    logic [4:0] h;
    logic neg;
    logic run;
    c[0] = w[7:0]; c[1] = w[15:8]; c[2] = w[23:16]; c[3] = w[31:24];
    pos = 3'd0; mag = '0; neg = 1'b0; run = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (run && pos == 3'(k) && is_ws(c[k])) pos = pos + 3'd1;
      else run = 1'b0;
    end
    if (pos < 3'd4 && (c[pos[1:0]] == "+" || c[pos[1:0]] == "-")) begin
      neg = c[pos[1:0]] == "-";
      pos = pos + 3'd1;
    end
    if (pos < 3'd2 && c[pos[1:0]] == "0" && (c[2'(pos + 3'd1)] | 8'h20) == "x" &&
        hex_of(c[2'(pos + 3'd2)]) < 5'd16) pos = pos + 3'd2;
    run = 1'b1;
    for (int k = 0; k < 4; k++) begin
      h = hex_of(c[k]);
      if (run && 3'(k) >= pos) begin
        if (h < 5'd16) mag = {mag[12:0], h[3:0]};
        else run = 1'b0;
      end
    end
    if (neg && mag != '0) decode_u = "?";
    else if (mag < 17'h80) decode_u = mag[7:0];
    else decode_u = "?";
  endfunction
endpackage

### src/fjp_front.sv
// Front part: accepts items, classifies each, and queues it for the back part.
// Depends on fjp_pkg.
`timescale 1ns / 1ps
module fjp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          text_byte,
  input  logic                end_marker,
  output logic                tok_valid,
  output fjp_pkg::tok_t       tok,
  input  logic                tok_take
);
  fjp_pkg::tok_t mem [fjp_pkg::QueueDepth];
  logic [fjp_pkg::QIdxW-1:0] wr_ptr, rd_ptr;
  logic [fjp_pkg::QIdxW:0] count;
  fjp_pkg::tok_t in_tok;
  logic do_push, do_pop;

  // Classify the incoming item.
  always_comb begin
    in_tok.text_byte = text_byte;
    if (end_marker) in_tok.cls = fjp_pkg::C_END;
    else if (fjp_pkg::is_ws(text_byte)) in_tok.cls = fjp_pkg::C_WS;
    else in_tok.cls = fjp_pkg::C_BYTE;
  end

  assign full = count == (fjp_pkg::QIdxW + 1)'(fjp_pkg::QueueDepth);
  assign tok_valid = count != '0;
  assign tok = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = tok_take && tok_valid;

  // Store the item.
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= in_tok;
  end

  // Advance pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (fjp_pkg::QIdxW + 1)'(do_push) - (fjp_pkg::QIdxW + 1)'(do_pop);
    end
  end
endmodule

### src/fjp_back.sv
// Back part: runs the parse state machine, one result per cycle, into an output register;
// it stalls while that register is full and not popped. Depends on fjp_pkg.
`timescale 1ns / 1ps
module fjp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                tok_valid,
  input  fjp_pkg::tok_t       tok,
  output logic                tok_take,
  output logic                empty,
  input  logic                pop,
  output logic [2:0]          result_kind,
  output logic [7:0]          decoded_char,
  output logic [2:0]          error_code,
  output logic                last_of_run
);
  fjp_pkg::phase_t phase, phase_next;
  logic esc, esc_next;
  logic [2:0] ucnt, ucnt_next;
  logic [31:0] uch, uch_next;
  logic [fjp_pkg::PendCntW-1:0] pcnt, pcnt_next;
  logic [fjp_pkg::PendCntW-1:0] flush, flush_next;  // held spaces emitted so far
  logic [1:0] step, step_next;                      // sub-result within one item
  logic [7:0] spaces [fjp_pkg::PendingDepth];
  logic [7:0] sp_rd;

  logic out_valid;
  logic [2:0] o_kind, o_err;
  logic [7:0] o_char;
  logic o_last;
  logic em, em_last, finish, sp_wr;
  logic [2:0] em_kind, em_err;
  logic [7:0] em_char;
  logic [7:0] b;
  logic can_go;

  assign b = tok.text_byte;
  assign can_go = tok_valid && (!out_valid || pop);
  assign sp_rd = spaces[flush[fjp_pkg::PendIdxW-1:0]];

  // Decide next state and the result, if any, of this cycle.
  always_comb begin
    phase_next = phase; esc_next = esc; ucnt_next = ucnt; uch_next = uch;
    pcnt_next = pcnt; flush_next = flush; step_next = step;
    em = 1'b0; em_last = 1'b1; em_kind = fjp_pkg::K_KEYCH; em_char = '0; em_err = '0;
    finish = 1'b1; sp_wr = 1'b0;
    if (tok.cls == fjp_pkg::C_END) begin
      phase_next = fjp_pkg::PH_START; esc_next = 1'b0; ucnt_next = '0; uch_next = '0;
      pcnt_next = '0; step_next = '0;
      case (phase)
        fjp_pkg::PH_START: begin em = 1'b1; em_kind = fjp_pkg::K_ERROR; em_err = fjp_pkg::E_NOBRACE; end
        fjp_pkg::PH_OPEN, fjp_pkg::PH_COMMA: begin em = 1'b1; em_kind = fjp_pkg::K_DONE; end
        fjp_pkg::PH_KEYWAIT, fjp_pkg::PH_KEYSTR: begin
          em = 1'b1; em_kind = fjp_pkg::K_ERROR; em_err = fjp_pkg::E_BADKEY;
        end
        fjp_pkg::PH_COLON: begin em = 1'b1; em_kind = fjp_pkg::K_ERROR; em_err = fjp_pkg::E_NOCOLON; end
        fjp_pkg::PH_VALSTR: begin em = 1'b1; em_kind = fjp_pkg::K_ERROR; em_err = fjp_pkg::E_BADVAL; end
        fjp_pkg::PH_AFTERVAL: begin em = 1'b1; em_kind = fjp_pkg::K_ERROR; em_err = fjp_pkg::E_NOSEP; end
        fjp_pkg::PH_VALWAIT, fjp_pkg::PH_BARE: begin
          em = 1'b1;
          if (step == 2'd0) begin
            em_kind = fjp_pkg::K_PAIREND; em_last = 1'b0; finish = 1'b0; step_next = 2'd1;
            phase_next = phase; pcnt_next = pcnt;
          end else begin
            em_kind = fjp_pkg::K_ERROR; em_err = fjp_pkg::E_NOSEP;
          end
        end
        default: ;
      endcase
    end else begin
      case (phase)
        fjp_pkg::PH_START: begin
          if (tok.cls != fjp_pkg::C_WS) begin
            if (b == "{") phase_next = fjp_pkg::PH_OPEN;
            else begin
              em = 1'b1; em_kind = fjp_pkg::K_ERROR; em_err = fjp_pkg::E_NOBRACE;
              phase_next = fjp_pkg::PH_FAILED;
            end
          end
        end
        fjp_pkg::PH_OPEN, fjp_pkg::PH_COMMA, fjp_pkg::PH_KEYWAIT: begin
          if (tok.cls == fjp_pkg::C_WS) begin
            if (phase == fjp_pkg::PH_COMMA) phase_next = fjp_pkg::PH_KEYWAIT;
          end else if (b == "}" && phase == fjp_pkg::PH_OPEN) begin
            em = 1'b1; em_kind = fjp_pkg::K_DONE; phase_next = fjp_pkg::PH_DONE;
          end else if (b == "\"") phase_next = fjp_pkg::PH_KEYSTR;
          else begin
            em = 1'b1; em_kind = fjp_pkg::K_ERROR; em_err = fjp_pkg::E_BADKEY;
            phase_next = fjp_pkg::PH_FAILED;
          end
        end
        fjp_pkg::PH_KEYSTR, fjp_pkg::PH_VALSTR: begin
          em_kind = (phase == fjp_pkg::PH_KEYSTR) ? fjp_pkg::K_KEYCH : fjp_pkg::K_VALCH;
          if (ucnt != '0) begin
            case (ucnt[1:0])
              2'd1: uch_next[7:0] = b;
              2'd2: uch_next[15:8] = b;
              2'd3: uch_next[23:16] = b;
              default: uch_next[31:24] = b;
            endcase
            if (ucnt == 3'd4) begin
              em = 1'b1; em_char = fjp_pkg::decode_u({b, uch[23:0]});
              ucnt_next = '0; uch_next = '0;
            end else ucnt_next = ucnt + 3'd1;
          end else if (esc) begin
            esc_next = 1'b0;
            case (b)
              "n": begin em = 1'b1; em_char = 8'h0a; end
              "t": begin em = 1'b1; em_char = 8'h09; end
              "r": begin em = 1'b1; em_char = 8'h0d; end
              "b": begin em = 1'b1; em_char = 8'h08; end
              "f": begin em = 1'b1; em_char = 8'h0c; end
              "u": begin ucnt_next = 3'd1; uch_next = '0; end
              default: begin em = 1'b1; em_char = b; end
            endcase
          end else if (b == "\\") esc_next = 1'b1;
          else if (b == "\"") begin
            em = 1'b1;
            if (phase == fjp_pkg::PH_KEYSTR) begin
              em_kind = fjp_pkg::K_KEYEND; phase_next = fjp_pkg::PH_COLON;
            end else begin
              em_kind = fjp_pkg::K_PAIREND; phase_next = fjp_pkg::PH_AFTERVAL;
            end
          end else begin em = 1'b1; em_char = b; end
        end
        fjp_pkg::PH_COLON: begin
          if (tok.cls != fjp_pkg::C_WS) begin
            if (b == ":") phase_next = fjp_pkg::PH_VALWAIT;
            else begin
              em = 1'b1; em_kind = fjp_pkg::K_ERROR; em_err = fjp_pkg::E_NOCOLON;
              phase_next = fjp_pkg::PH_FAILED;
            end
          end
        end
        fjp_pkg::PH_VALWAIT, fjp_pkg::PH_BARE: begin
          if (phase == fjp_pkg::PH_VALWAIT && tok.cls == fjp_pkg::C_WS) ;
          else if (phase == fjp_pkg::PH_VALWAIT && b == "\"") phase_next = fjp_pkg::PH_VALSTR;
          else if (b == "," || b == "}") begin
            pcnt_next = '0; em = 1'b1; em_kind = fjp_pkg::K_PAIREND;
            if (b == ",") phase_next = fjp_pkg::PH_COMMA;
            else if (step == 2'd0) begin
              em_last = 1'b0; finish = 1'b0; step_next = 2'd1; pcnt_next = pcnt;
            end else begin
              em_kind = fjp_pkg::K_DONE; phase_next = fjp_pkg::PH_DONE; step_next = '0;
            end
          end else if (tok.cls == fjp_pkg::C_WS) begin
            phase_next = fjp_pkg::PH_BARE;
            if (pcnt == fjp_pkg::PendCntW'(fjp_pkg::PendingDepth)) begin
              pcnt_next = '0; em = 1'b1; em_kind = fjp_pkg::K_ERROR;
              em_err = fjp_pkg::E_OVERFLOW; phase_next = fjp_pkg::PH_FAILED;
            end else begin
              sp_wr = 1'b1; pcnt_next = pcnt + 1'b1;
            end
          end else begin
            // Flush held whitespace one per cycle while the output can take it, then the byte itself.
            em = 1'b1; em_kind = fjp_pkg::K_VALCH;
            if (flush < pcnt) begin
              em_char = sp_rd; em_last = 1'b0; finish = 1'b0; flush_next = flush + 1'b1;
            end else begin
              em_char = b; flush_next = '0; pcnt_next = '0; phase_next = fjp_pkg::PH_BARE;
            end
          end
        end
        fjp_pkg::PH_AFTERVAL: begin
          if (tok.cls != fjp_pkg::C_WS) begin
            if (b == ",") phase_next = fjp_pkg::PH_COMMA;
            else if (b == "}") begin
              em = 1'b1; em_kind = fjp_pkg::K_DONE; phase_next = fjp_pkg::PH_DONE;
            end else begin
              em = 1'b1; em_kind = fjp_pkg::K_ERROR; em_err = fjp_pkg::E_NOSEP;
              phase_next = fjp_pkg::PH_FAILED;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign tok_take = can_go && finish;

  // Hold whitespace of a bare value.
  always_ff @(posedge clk) begin
    if (can_go && sp_wr) spaces[pcnt[fjp_pkg::PendIdxW-1:0]] <= b;
  end

  // Advance parse state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= fjp_pkg::PH_START; esc <= 1'b0; ucnt <= '0; uch <= '0;
      pcnt <= '0; flush <= '0; step <= '0; out_valid <= 1'b0;
    end else begin
      if (can_go) begin
        phase <= phase_next; esc <= esc_next; ucnt <= ucnt_next; uch <= uch_next;
        pcnt <= pcnt_next; flush <= flush_next; step <= step_next;
      end
      if (can_go && em) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  // Load the output register.
  always_ff @(posedge clk) begin
    if (can_go && em) begin
      o_kind <= em_kind; o_char <= em_char; o_err <= em_err; o_last <= em_last;
    end
  end

  assign empty = !out_valid;
  assign result_kind = o_kind;
  assign decoded_char = o_char;
  assign error_code = o_err;
  assign last_of_run = o_last;
endmodule

### src/flat_json_object_parser_unit.sv
// An item's first result passes through the front queue and the back output register to the result ports.
// The back part takes one item at a time; it waits while its output register is full and not popped.
// A bare value byte after held whitespace bytes is taken only after each held byte has been given out.
// Reset (rst, synchronous) empties the queue and returns to awaiting '{'.
// Top level: front queue and back parser. Depends on fjp_pkg, fjp_front, fjp_back.
`timescale 1ns / 1ps
module flat_json_object_parser_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_byte,
  input  logic       end_marker,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] result_kind,
  output logic [7:0] decoded_char,
  output logic [2:0] error_code,
  output logic       last_of_run
);
  logic tok_valid, tok_take;
  fjp_pkg::tok_t tok;

  fjp_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .text_byte(text_byte),
    .end_marker(end_marker), .tok_valid(tok_valid), .tok(tok), .tok_take(tok_take)
  );

  fjp_back u_back (
    .clk(clk), .rst(rst), .tok_valid(tok_valid), .tok(tok), .tok_take(tok_take),
    .empty(empty), .pop(pop), .result_kind(result_kind), .decoded_char(decoded_char),
    .error_code(error_code), .last_of_run(last_of_run)
  );
endmodule

### src/fjp_checker.sv
// Port checker for the parser top level, bound to it below.
// Depends on fjp_pkg and flat_json_object_parser_unit_assert.svh.
`timescale 1ns / 1ps
`include "flat_json_object_parser_unit_assert.svh"
module fjp_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [2:0] result_kind,
  input logic [7:0] decoded_char,
  input logic [2:0] error_code
);
  `FJP_ASSERT_IMP(a_kind_range, clk, rst, !empty, result_kind <= fjp_pkg::K_ERROR, "bad kind")
  `FJP_ASSERT_IMP(a_err_zero, clk, rst, !empty && result_kind != fjp_pkg::K_ERROR, error_code == fjp_pkg::E_NOBRACE, "stray error")
  `FJP_ASSERT_IMP(a_char_zero, clk, rst, !empty && result_kind > fjp_pkg::K_VALCH, decoded_char == 8'd0, "stray char")
  `FJP_ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(result_kind), "result dropped")
endmodule

bind flat_json_object_parser_unit fjp_checker u_fjp_checker (
  .clk(clk), .rst(rst), .empty(empty), .pop(pop), .result_kind(result_kind),
  .decoded_char(decoded_char), .error_code(error_code)
);

### tb/testbench.sv
// Testbench for flat_json_object_parser_unit: random and directed request text,
// predicted result items checked in order. Depends on fjp_pkg and the block RTL.
`timescale 1ns / 1ps
module testbench;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic [2:0] err;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [7:0] b;
    logic       endm;
  } item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic [7:0] text_byte = '0;
  logic end_marker = 1'b0;
  logic pop = 1'b0;
  logic full, empty, last_of_run;
  logic [2:0] result_kind, error_code;
  logic [7:0] decoded_char;

  flat_json_object_parser_unit u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .text_byte(text_byte),
    .end_marker(end_marker), .empty(empty), .pop(pop), .result_kind(result_kind),
    .decoded_char(decoded_char), .error_code(error_code), .last_of_run(last_of_run)
  );

  item_t pending_items[$];
  res_t expected_results[$];
  int mode = 0;          // 0: receiver idles more, 1: sender idles more, 2: none
  bit hold_pop = 1'b0;
  bit stim_done = 1'b0;
  int mismatches = 0;
  int idle_cycles = 0;

  // Predictor state
  fjp_pkg::phase_t ph = fjp_pkg::PH_START;
  bit esc = 1'b0;
  int ucnt = 0;
  logic [31:0] uchars = '0;
  logic [7:0] spaces[fjp_pkg::PendingDepth];
  int scnt = 0;
  res_t step_out[$];

  initial forever #4 clk = ~clk;

  function automatic bit ws(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic int hexv(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return 16;
  endfunction

  function automatic logic [7:0] unicode_char(input logic [31:0] w);
    logic [7:0] c[4];
    int pos, mag;
    bit neg;
    pos = 0; mag = 0; neg = 0;
    for (int k = 0; k < 4; k++) c[k] = w[8*k +: 8];
    while (pos < 4 && ws(c[pos])) pos++;
    if (pos < 4 && (c[pos] == "+" || c[pos] == "-")) begin
      neg = c[pos] == "-";
      pos++;
    end
    if (pos + 2 < 4 && c[pos] == "0" && (c[pos+1] | 8'h20) == "x" && hexv(c[pos+2]) < 16)
      pos += 2;
    while (pos < 4 && hexv(c[pos]) < 16) begin
      mag = mag * 16 + hexv(c[pos]);
      pos++;
    end
    if (neg && mag != 0) return "?";
    return mag < 'h80 ? 8'(mag) : "?";
  endfunction

  function automatic void add(input fjp_pkg::kind_t k, input logic [7:0] c,
                              input logic [2:0] e);
    res_t r;
    r = '{k, c, e, 1'b0};
    step_out.insert(step_out.size(), r);
  endfunction

  function automatic void abort(input logic [2:0] e);
    add(fjp_pkg::K_ERROR, 8'h00, e);
    ph = fjp_pkg::PH_FAILED;
  endfunction

  // Decode one quoted-string byte; return 1 on the closing quote.
  function automatic bit string_char(input logic [7:0] b, input fjp_pkg::kind_t k);
    if (ucnt != 0) begin
      uchars |= 32'(b) << (8 * ((ucnt - 1) & 3));
      ucnt++;
      if (ucnt >= 5) begin
        add(k, unicode_char(uchars), 3'd0);
        ucnt = 0;
        uchars = '0;
      end
      return 0;
    end
    if (esc) begin
      esc = 0;
      case (b)
        "n": add(k, 8'h0a, 3'd0);
        "t": add(k, 8'h09, 3'd0);
        "r": add(k, 8'h0d, 3'd0);
        "b": add(k, 8'h08, 3'd0);
        "f": add(k, 8'h0c, 3'd0);
        "u": begin ucnt = 1; uchars = '0; end
        default: add(k, b, 3'd0);
      endcase
      return 0;
    end
    if (b == "\\") begin esc = 1; return 0; end
    if (b == "\"") return 1;
    add(k, b, 3'd0);
    return 0;
  endfunction

  // Predict the result items of one input item and queue them.
  function automatic void predict_item(input item_t it);
    logic [7:0] b;
    b = it.b;
    step_out.delete();
    if (it.endm) begin
      case (ph)
        fjp_pkg::PH_START: abort(fjp_pkg::E_NOBRACE);
        fjp_pkg::PH_OPEN, fjp_pkg::PH_COMMA: add(fjp_pkg::K_DONE, 8'h00, 3'd0);
        fjp_pkg::PH_KEYWAIT, fjp_pkg::PH_KEYSTR: abort(fjp_pkg::E_BADKEY);
        fjp_pkg::PH_COLON: abort(fjp_pkg::E_NOCOLON);
        fjp_pkg::PH_VALWAIT, fjp_pkg::PH_BARE: begin
          add(fjp_pkg::K_PAIREND, 8'h00, 3'd0); abort(fjp_pkg::E_NOSEP);
        end
        fjp_pkg::PH_VALSTR: abort(fjp_pkg::E_BADVAL);
        fjp_pkg::PH_AFTERVAL: abort(fjp_pkg::E_NOSEP);
        default: ;
      endcase
      ph = fjp_pkg::PH_START; esc = 0; ucnt = 0; uchars = '0; scnt = 0;
    end else begin
      case (ph)
        fjp_pkg::PH_START:
          if (!ws(b)) begin
            if (b == "{") ph = fjp_pkg::PH_OPEN; else abort(fjp_pkg::E_NOBRACE);
          end
        fjp_pkg::PH_OPEN, fjp_pkg::PH_COMMA, fjp_pkg::PH_KEYWAIT:
          if (ws(b)) begin
            if (ph == fjp_pkg::PH_COMMA) ph = fjp_pkg::PH_KEYWAIT;
          end else if (b == "}" && ph == fjp_pkg::PH_OPEN) begin
            add(fjp_pkg::K_DONE, 8'h00, 3'd0); ph = fjp_pkg::PH_DONE;
          end else if (b == "\"") ph = fjp_pkg::PH_KEYSTR;
          else abort(fjp_pkg::E_BADKEY);
        fjp_pkg::PH_KEYSTR:
          if (string_char(b, fjp_pkg::K_KEYCH)) begin
            add(fjp_pkg::K_KEYEND, 8'h00, 3'd0); ph = fjp_pkg::PH_COLON;
          end
        fjp_pkg::PH_COLON:
          if (!ws(b)) begin
            if (b == ":") ph = fjp_pkg::PH_VALWAIT; else abort(fjp_pkg::E_NOCOLON);
          end
        fjp_pkg::PH_VALWAIT, fjp_pkg::PH_BARE:
          if (ph == fjp_pkg::PH_VALWAIT && ws(b)) ;
          else if (ph == fjp_pkg::PH_VALWAIT && b == "\"") ph = fjp_pkg::PH_VALSTR;
          else if (b == "," || b == "}") begin
            scnt = 0;
            add(fjp_pkg::K_PAIREND, 8'h00, 3'd0);
            if (b == ",") ph = fjp_pkg::PH_COMMA;
            else begin add(fjp_pkg::K_DONE, 8'h00, 3'd0); ph = fjp_pkg::PH_DONE; end
          end else begin
            ph = fjp_pkg::PH_BARE;
            if (ws(b)) begin
              if (scnt >= fjp_pkg::PendingDepth) begin
                scnt = 0; abort(fjp_pkg::E_OVERFLOW);
              end else begin spaces[scnt] = b; scnt++; end
            end else begin
              for (int k = 0; k < scnt; k++) add(fjp_pkg::K_VALCH, spaces[k], 3'd0);
              scnt = 0;
              add(fjp_pkg::K_VALCH, b, 3'd0);
            end
          end
        fjp_pkg::PH_VALSTR:
          if (string_char(b, fjp_pkg::K_VALCH)) begin
            add(fjp_pkg::K_PAIREND, 8'h00, 3'd0); ph = fjp_pkg::PH_AFTERVAL;
          end
        fjp_pkg::PH_AFTERVAL:
          if (!ws(b)) begin
            if (b == ",") ph = fjp_pkg::PH_COMMA;
            else if (b == "}") begin
              add(fjp_pkg::K_DONE, 8'h00, 3'd0); ph = fjp_pkg::PH_DONE;
            end else abort(fjp_pkg::E_NOSEP);
          end
        default: ;
      endcase
    end
    if (step_out.size() > 0) step_out[$].last = 1'b1;
    foreach (step_out[i]) expected_results.insert(expected_results.size(), step_out[i]);
  endfunction

  // Stimulus builders
  task automatic put(input logic [7:0] b);
    item_t it;
    it = '{b, 1'b0};
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic put_end();
    item_t it;
    it = '{8'($urandom_range(255)), 1'b1};
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  function automatic logic [7:0] rand_ws();
    logic [7:0] w[6] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
    return w[$urandom_range(5)];
  endfunction

  function automatic logic [7:0] rand_text();
    int r;
    r = $urandom_range(9);
    if (r < 6) return 8'($urandom_range(8'h7e, 8'h21));
    if (r < 8) return 8'($urandom_range(255));
    return rand_ws();
  endfunction

  task automatic put_string_body();
    int n;
    string hexset;
    hexset = "0123456789abcdefABx+- ";
    n = $urandom_range(5);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0: begin put("\\"); put(rand_text()); end
        1: begin
          put("\\"); put("u");
          for (int j = 0; j < 4; j++)
            put($urandom_range(3) == 0 ? rand_text() : hexset[$urandom_range(21)]);
        end
        default: begin
          logic [7:0] c;
          c = rand_text();
          if (c == "\"" || c == "\\") c = "a";
          put(c);
        end
      endcase
    end
  endtask

  task automatic put_object();
    int pairs;
    if ($urandom_range(3) == 0) put(rand_ws());
    put("{");
    pairs = $urandom_range(3);
    for (int p = 0; p < pairs; p++) begin
      if (p > 0) begin put(","); if ($urandom_range(3) == 0) put(rand_ws()); end
      put("\""); put_string_body(); put("\"");
      if ($urandom_range(3) == 0) put(rand_ws());
      put(":");
      if ($urandom_range(1)) begin
        put("\""); put_string_body(); put("\"");
        if ($urandom_range(3) == 0) put(rand_ws());
      end else begin
        int n;
        n = $urandom_range(6);
        for (int i = 0; i < n; i++) begin
          logic [7:0] c;
          c = $urandom_range(2) == 0 ? rand_ws() : rand_text();
          if (c == "," || c == "}") c = "7";
          put(c);
        end
        if ($urandom_range(5) == 0) for (int i = 0; i < 17; i++) put(rand_ws());
      end
      // Occasionally break the sequence
      if ($urandom_range(11) == 0) put(rand_text());
    end
    case ($urandom_range(9))
      0: ;
      1: put(",");
      default: put("}");
    endcase
    if ($urandom_range(3) == 0) put(rand_text());
    put_end();
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Directed and random stimulus, one idling mode per phase
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    put_end();
    put_str("{"); put_end();
    put_str(" {}"); put_end();
    put_str("{\"a\":1,"); put_end();
    put_str("{\"a\":1, "); put_end();
    put_str("x"); put_end();
    put_str("{\"k\\n\\t\\r\\b\\f\\q\":\"\\u0041\\u00ff\\u-001\\u 0x7\"}"); put_end();
    put_str("{\"a\" : b  c \t}"); put(8'hff); put(8'h00); put_end();
    for (int m = 0; m < 3; m++) begin
      mode = m;
      for (int o = 0; o < 3; o++) put_object();
      if (m == 0) begin
        put_str("{\"k\":v"); for (int i = 0; i < 17; i++) put(8'h20); put_end();
        put_str("{\"k\":v   "); put_end();
        put_str("{\"k\"x"); put_end();
        put_str("{\"k\":\"ab"); put_end();
        put_str("{\"k\":\"ab\" x"); put_end();
        put_str("{\"k\":\"ab\""); put_end();
        put_str("{\"k\""); put_end();
        put_str("{\"k"); put_end();
        put_str("{\"k\":"); put_end();
        put_str("{1"); put_end();
      end
      if (m == 1) begin
        // Long receiver hold while the sender keeps pushing
        hold_pop = 1'b1;
        repeat (300) @(posedge clk);
        hold_pop = 1'b0;
      end
      wait_drained();
    end
    stim_done = 1'b1;
  end

  // Driver
  always @(posedge clk) begin
    bit took;
    if (!rst) begin
      took = push && !full;
      if (took) begin
        predict_item(pending_items[0]);
        pending_items.delete(0);
      end
      if (pending_items.size() > 0 &&
          !(mode == 0 && $urandom_range(99) < 18) && !(mode == 1 && $urandom_range(99) < 50)) begin
        push <= 1'b1;
        text_byte <= pending_items[0].b;
        end_marker <= pending_items[0].endm;
      end else if (!(push && full)) begin
        push <= 1'b0;
      end
    end
  end

  // Monitor and receiver
  always @(posedge clk) begin
    res_t got, want;
    if (!rst) begin
      if (pop && !empty) begin
        got = '{result_kind, decoded_char, error_code, last_of_run};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item: %p", got);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      pop <= !hold_pop && !(mode == 1 && $urandom_range(99) < 18) &&
             !(mode == 0 && $urandom_range(99) < 50);
    end
  end

  // Watchdog and end of run
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || rst || hold_pop) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (stim_done) begin
      if (mismatches == 0 && expected_results.size() == 0)
        $display("** flat_json_object_parser_unit: PASSED **");
      else
        $display("** flat_json_object_parser_unit: FAILED **");
      $finish;
    end else if (idle_cycles >= WatchLimit) begin
      $display("** flat_json_object_parser_unit: FAILED **");
      $finish;
    end
  end
endmodule
